>>> rtl/box_mean_filter_7x7_top_macros.svh
// Assertion macros for the box mean filter.
// Define ASSERT_OFF to compile the checks out.
`ifndef BOX_MEAN_FILTER_7X7_TOP_MACROS_SVH
`define BOX_MEAN_FILTER_7X7_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define BMF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BMF_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BMF_ASSERT(lbl, clk, rst_n, prop, msg)
`define BMF_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/bmf_pkg.sv
package bmf_pkg;

    localparam int PIX_W      = 8;
    localparam int COL_OUT_W  = 10;
    localparam int ROW_W      = 12;
    localparam int POS_W      = 12;   // holds any column up to 4095
    localparam int CFG_W_W    = 11;
    localparam int CFG_H_W    = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam int Q_DEPTH    = 8;
    localparam int Q_PTR_W    = 3;
    localparam int Q_CNT_W    = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } t_cfg_reg;

    // position of the pixel being taken in
    typedef struct packed {
        logic [POS_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             border;
        logic             interior;
    } t_pos;

    // pipeline status toward the top level
    typedef struct packed {
        logic s1_valid;
        logic s1_fwd;
    } t_win_stat;

    // last datapath stage toward the result queue
    typedef struct packed {
        logic             valid;
        logic             border;
        logic             interior;
        logic [POS_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] mean;
    } t_emit;

    typedef struct packed {
        logic [COL_OUT_W-1:0] out_col;
        logic [ROW_W-1:0]     out_row;
        logic [PIX_W-1:0]     value;
        logic                 last;
    } t_result;

endpackage

>>> rtl/bmf_if.sv
interface bmf_pix_if import bmf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface bmf_res_if import bmf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [COL_OUT_W-1:0] out_col;
    logic [ROW_W-1:0]     out_row;
    logic [PIX_W-1:0]     value;
    logic                 last;

    modport source (output valid, output out_col, output out_row, output value,
                    output last, input ready);
    modport sink   (input valid, input out_col, input out_row, input value,
                    input last, output ready);
endinterface

interface bmf_cfg_if import bmf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/bmf_ram.sv
module bmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bmf_ctl.sv
module bmf_ctl import bmf_pkg::*; #(
    parameter int MAX_WIDTH = 1024,
    parameter int RADIUS    = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_accept,
    input  logic                  i_frame_start,
    output t_pos                  o_pos
);

    localparam int SPAN = 2 * RADIUS + 1;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int LW   = (WW > CFG_W_W) ? WW : CFG_W_W;
    localparam int HW   = ROW_W + 1;

    logic [CFG_W_W-1:0] r_width;
    logic [CFG_H_W-1:0] r_height;
    logic [CW-1:0]      r_col;
    logic [ROW_W-1:0]   r_row;
    logic [CW-1:0]      n_col;
    logic [ROW_W-1:0]   n_row;

    logic [LW-1:0]    w_cfg;
    logic [LW-1:0]    w_eff;
    logic [ROW_W-1:0] h_eff;
    logic [CW-1:0]    c0;
    logic [ROW_W-1:0] r0;
    logic             wrap;
    logic [HW-1:0]    row_a;
    logic [CW-1:0]    col;
    logic [ROW_W-1:0] row;
    logic [CW:0]      col_p1;
    logic [HW-1:0]    row_p1;
    logic             end_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_W_W'(640);
            r_height <= CFG_H_W'(480);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_width  <= i_cfg_data[CFG_W_W-1:0];
                REG_FRAME_HEIGHT: r_height <= i_cfg_data[CFG_H_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // effective frame size
    always_comb begin
        w_cfg = LW'(r_width);
        if (w_cfg < LW'(SPAN)) begin
            w_eff = LW'(SPAN);
        end else if (w_cfg > LW'(MAX_WIDTH)) begin
            w_eff = LW'(MAX_WIDTH);
        end else begin
            w_eff = w_cfg;
        end
        h_eff = (r_height < ROW_W'(SPAN)) ? ROW_W'(SPAN) : r_height;
    end

    // position of the incoming pixel, then the one after it
    always_comb begin
        c0     = i_frame_start ? '0 : r_col;
        r0     = i_frame_start ? '0 : r_row;
        wrap   = LW'(c0) >= w_eff;
        col    = wrap ? '0 : c0;
        row_a  = wrap ? (HW'(r0) + HW'(1)) : HW'(r0);
        row    = (row_a >= HW'(h_eff)) ? '0 : row_a[ROW_W-1:0];

        col_p1  = (CW+1)'(col) + (CW+1)'(1);
        row_p1  = HW'(row) + HW'(1);
        end_row = LW'(col_p1) >= w_eff;
        n_col   = end_row ? '0 : col_p1[CW-1:0];
        if (!end_row) begin
            n_row = row;
        end else if (row_p1 >= HW'(h_eff)) begin
            n_row = '0;
        end else begin
            n_row = row_p1[ROW_W-1:0];
        end
    end

    always_comb begin
        o_pos.col      = POS_W'(col);
        o_pos.row      = row;
        o_pos.border   = (row < ROW_W'(RADIUS)) || (row >= h_eff - ROW_W'(RADIUS)) ||
                         (col < CW'(RADIUS)) || (LW'(col) >= w_eff - LW'(RADIUS));
        o_pos.interior = (col >= CW'(2 * RADIUS)) && (row >= ROW_W'(2 * RADIUS));
    end

endmodule

>>> rtl/bmf_win.sv
module bmf_win import bmf_pkg::*; #(
    parameter int MAX_WIDTH = 1024,
    parameter int RADIUS    = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic                         i_accept,
    input  t_pos                         i_pos,
    input  logic [PIX_W-1:0]             i_pix,
    input  logic [PIX_W*2*RADIUS-1:0]    i_ram_rdata,
    output logic                         o_ram_we,
    output logic [$clog2(MAX_WIDTH)-1:0] o_ram_waddr,
    output logic [PIX_W*2*RADIUS-1:0]    o_ram_wdata,
    output t_win_stat                    o_stat,
    output t_emit                        o_emit
);

    localparam int SPAN  = 2 * RADIUS + 1;
    localparam int LINES = 2 * RADIUS;
    localparam int LBW   = PIX_W * LINES;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int CSW   = $clog2(SPAN * 255 + 1);
    localparam int SW    = $clog2(SPAN * SPAN * 255 + 1);
    localparam int DIV   = SPAN * SPAN;
    localparam int QSH   = SW + $clog2(DIV) + 1;
    localparam logic [QSH-1:0] RECIP = QSH'(((1 << QSH) + DIV - 1) / DIV);

    // stage 1: line buffer data arrives
    logic             r_s1_valid;
    t_pos             r_s1_pos;
    logic [PIX_W-1:0] r_s1_pix;
    logic             r_s1_fwd;
    logic [LBW-1:0]   r_s1_fwd_word;

    // stage 2: column sums
    logic             r_s2_valid;
    t_pos             r_s2_pos;
    logic [PIX_W-1:0] r_s2_pix;
    logic [CSW-1:0]   r_s2_add;
    logic [CSW-1:0]   r_s2_sub;
    logic [CSW-1:0]   r_cs [SPAN];

    // stage 3: window sum and mean
    logic             r_s3_valid;
    t_pos             r_s3_pos;
    logic [PIX_W-1:0] r_s3_pix;
    logic [SW-1:0]    r_s3_sum;
    logic [SW-1:0]    r_sum;
    logic [SW-1:0]    n_sum;

    logic [LBW-1:0]     word;
    logic [LBW-1:0]     wr_word;
    logic [CSW-1:0]     colsum;
    logic [SW+QSH-1:0]  prod;

    // lines above the top row of the frame are stale or unwritten; they never
    // reach a window that is emitted, so they are left out of the column sum
    always_comb begin
        word    = r_s1_fwd ? r_s1_fwd_word : i_ram_rdata;
        wr_word = {r_s1_pix, word[LBW-1:PIX_W]};
        colsum  = CSW'(r_s1_pix);
        for (int k = 0; k < LINES; k++) begin
            if (r_s1_pos.row >= ROW_W'(LINES - k)) begin
                colsum = colsum + CSW'(word[PIX_W*k +: PIX_W]);
            end
        end
    end

    assign o_ram_we    = r_s1_valid && i_adv;
    assign o_ram_waddr = r_s1_pos.col[CW-1:0];
    assign o_ram_wdata = wr_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (i_adv) begin
            r_s1_valid <= i_accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    // same column written back while read again: take the written word
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_pos      <= i_pos;
            r_s1_pix      <= i_pix;
            r_s1_fwd      <= r_s1_valid && (r_s1_pos.col == i_pos.col);
            r_s1_fwd_word <= wr_word;
        end
    end

    assign n_sum = r_sum + SW'(r_s2_add) - SW'(r_s2_sub);

    // running sums must start consistent, hence the reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SPAN; k++) begin
                r_cs[k] <= '0;
            end
            r_sum <= '0;
        end else if (i_adv) begin
            if (r_s1_valid) begin
                for (int k = 0; k < SPAN - 1; k++) begin
                    r_cs[k] <= r_cs[k+1];
                end
                r_cs[SPAN-1] <= colsum;
            end
            if (r_s2_valid) begin
                r_sum <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && r_s1_valid) begin
            r_s2_pos <= r_s1_pos;
            r_s2_pix <= r_s1_pix;
            r_s2_add <= colsum;
            r_s2_sub <= r_cs[0];
        end
        if (i_adv && r_s2_valid) begin
            r_s3_pos <= r_s2_pos;
            r_s3_pix <= r_s2_pix;
            r_s3_sum <= n_sum;
        end
    end

    // divide by SPAN*SPAN through the reciprocal
    assign prod = (SW+QSH)'(r_s3_sum) * (SW+QSH)'(RECIP);

    always_comb begin
        o_emit.valid    = r_s3_valid;
        o_emit.border   = r_s3_pos.border;
        o_emit.interior = r_s3_pos.interior;
        o_emit.col      = r_s3_pos.col;
        o_emit.row      = r_s3_pos.row;
        o_emit.pix      = r_s3_pix;
        o_emit.mean     = prod[QSH +: PIX_W];
        o_stat.s1_valid = r_s1_valid;
        o_stat.s1_fwd   = r_s1_fwd;
    end

endmodule

>>> rtl/bmf_outq.sv
module bmf_outq import bmf_pkg::*; #(
    parameter int RADIUS = 3
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_emit   i_emit,
    output logic    o_space,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_result
);

    t_result            r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_CNT_W-1:0] r_cnt;
    logic [Q_PTR_W-1:0] n_wp;
    logic [Q_PTR_W-1:0] n_rp;
    logic [Q_CNT_W-1:0] n_cnt;

    logic               push0;
    logic               push1;
    logic               pop;
    logic [Q_PTR_W-1:0] wp1;
    t_result            res_b;
    t_result            res_i;
    t_result            first;

    // room for two results before the stage ahead may move
    assign o_space = r_cnt <= Q_CNT_W'(Q_DEPTH - 2);
    assign o_valid = r_cnt != '0;
    assign o_result = r_q[r_rp];

    always_comb begin
        res_b.out_col = COL_OUT_W'(i_emit.col);
        res_b.out_row = i_emit.row;
        res_b.value   = i_emit.pix;
        res_b.last    = !i_emit.interior;
        res_i.out_col = COL_OUT_W'(i_emit.col - POS_W'(RADIUS));
        res_i.out_row = i_emit.row - ROW_W'(RADIUS);
        res_i.value   = i_emit.mean;
        res_i.last    = 1'b1;
        first         = i_emit.border ? res_b : res_i;

        push0 = i_emit.valid && o_space && (i_emit.border || i_emit.interior);
        push1 = i_emit.valid && o_space && i_emit.border && i_emit.interior;
        pop   = o_valid && i_ready;
        wp1   = r_wp + Q_PTR_W'(1);

        n_wp  = r_wp + Q_PTR_W'(push0) + Q_PTR_W'(push1);
        n_rp  = r_rp + Q_PTR_W'(pop);
        n_cnt = r_cnt + Q_CNT_W'(push0) + Q_CNT_W'(push1) - Q_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push0) begin
            r_q[r_wp] <= first;
        end
        if (push1) begin
            r_q[wp1] <= res_i;
        end
    end

endmodule

>>> rtl/box_mean_filter_7x7_top.sv
// Channel  Dir  Payload                          Transfer when
// -------  ---  -------------------------------  -------------------------
// i_cfg    in   index[1:0], data[11:0]           valid && ready (ready = 1)
// i_pix    in   pixel[7:0], frame_start          valid && ready
// o_res    out  out_col[9:0], out_row[11:0],     valid && ready
//               value[7:0], last
//
// One pixel per cycle in while the result queue has room; the line store RAM
// is read and written back once per pixel, so the read-modify-write loop on it sets the pace.
// Pixel to result passes through three datapath stages and the queue.
// Right-border columns from row 2*RADIUS on, and the last RADIUS rows, make
// two results per pixel; the 8-entry result queue then stalls i_pix ready.
// Reset is synchronous, active low; no clearing pass, the line store is
// never read before it is written for a window that is used.
`include "box_mean_filter_7x7_top_macros.svh"

module box_mean_filter_7x7_top import bmf_pkg::*; #(
    parameter int MAX_WIDTH = 1024,
    parameter int RADIUS    = 3
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bmf_cfg_if.sink   i_cfg,
    bmf_pix_if.sink   i_pix,
    bmf_res_if.source o_res
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int LBW = PIX_W * 2 * RADIUS;

    logic            adv;        // whole datapath moves one step
    logic            accept;     // input transfer
    t_pos            pos;
    t_win_stat       win_stat;
    t_emit           emit;
    t_result         result;

    // line store: one word per column, 2*RADIUS rows of bytes
    logic            ram_we;
    logic [CW-1:0]   ram_waddr;
    logic [LBW-1:0]  ram_wdata;
    logic            ram_re;
    logic [CW-1:0]   ram_raddr;
    logic [LBW-1:0]  ram_rdata;

    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = adv;
    assign accept      = i_pix.valid && adv;
    assign ram_re      = accept;
    assign ram_raddr   = pos.col[CW-1:0];

    bmf_ctl #(
        .MAX_WIDTH (MAX_WIDTH),
        .RADIUS    (RADIUS)
    ) u_ctl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .i_accept      (accept),
        .i_frame_start (i_pix.frame_start),
        .o_pos         (pos)
    );

    bmf_ram #(
        .WIDTH (LBW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bmf_win #(
        .MAX_WIDTH (MAX_WIDTH),
        .RADIUS    (RADIUS)
    ) u_win (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_accept    (accept),
        .i_pos       (pos),
        .i_pix       (i_pix.pixel),
        .i_ram_rdata (ram_rdata),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_stat      (win_stat),
        .o_emit      (emit)
    );

    bmf_outq #(
        .RADIUS (RADIUS)
    ) u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_emit   (emit),
        .o_space  (adv),
        .i_ready  (o_res.ready),
        .o_valid  (o_res.valid),
        .o_result (result)
    );

    assign o_res.out_col = result.out_col;
    assign o_res.out_row = result.out_row;
    assign o_res.value   = result.value;
    assign o_res.last    = result.last;

    // a read that collides with the write-back must use the written word
    `BMF_ASSERT(a_fwd_on_collision, i_clk, i_rst_n, ram_we && ram_re && (ram_waddr == ram_raddr) |=> win_stat.s1_fwd, "line store collision not forwarded")
    // every input transfer lands in stage 1
    `BMF_ASSERT(a_accept_fills_s1, i_clk, i_rst_n, accept |=> win_stat.s1_valid, "accepted pixel lost before stage 1")
    // the result queue is empty right after reset
    `BMF_ASSERT_RST(a_empty_after_reset, i_clk, !i_rst_n |=> !o_res.valid, "result valid right after reset")

endmodule

>>> sim/tb_box_mean_filter_7x7_top.sv
module tb_box_mean_filter_7x7_top import bmf_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    // Filter geometry mirrored from the block's defaults
    localparam int MAX_W = 1024;
    localparam int RAD   = 3;
    localparam int SPAN  = 2 * RAD + 1;
    localparam int LINES = 2 * RAD;
    localparam int AREA  = SPAN * SPAN;

    // Pixels still in the pipeline need to drain; leave margin before touching registers
    localparam int SETTLE_CYCLES  = 12;
    // Longest legal quiet stretch is the output hold-off plus one long stall
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 560;
    localparam int WIDE_ITEMS     = 60;
    localparam int MAX_REPORTS    = 40;

    // Register indexes the block does not map; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef enum logic {STEP_PIX, STEP_CFG} t_step_kind;
    typedef enum int {FILL_NOISE, FILL_WHITE, FILL_BLACK, FILL_SPECKLE} t_fill;

    typedef struct packed {
        t_step_kind            kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
        logic [PIX_W-1:0]      pixel;
        logic                  frame_start;
        logic                  typed;      // want holds the single result to see
        t_result               want;
    } t_step;

    localparam int NUM_DIRECTED = 27;

    // Directed opening. Starts from the reset geometry (640 x 480), so row 0
    // is all border and each pixel comes straight back with last set.
    // kind      index             data      pixel  fs    typed want: col row value last
    t_step directed_steps [NUM_DIRECTED] = '{
        '{STEP_PIX, '0,               '0,       8'h00, 1'b1, 1'b1, '{10'd0, 12'd0, 8'h00, 1'b1}},
        '{STEP_PIX, '0,               '0,       8'hFF, 1'b0, 1'b1, '{10'd1, 12'd0, 8'hFF, 1'b1}},
        '{STEP_PIX, '0,               '0,       8'hA5, 1'b0, 1'b1, '{10'd2, 12'd0, 8'hA5, 1'b1}},
        '{STEP_PIX, '0,               '0,       8'h5A, 1'b0, 1'b1, '{10'd3, 12'd0, 8'h5A, 1'b1}},
        // width 0 with the dead bit 11 set: clamps up to 7
        '{STEP_CFG, REG_FRAME_WIDTH,  12'h800,  8'h00, 1'b0, 1'b0, '0},
        '{STEP_PIX, '0,               '0,       8'h01, 1'b0, 1'b1, '{10'd4, 12'd0, 8'h01, 1'b1}},
        '{STEP_PIX, '0,               '0,       8'h80, 1'b0, 1'b1, '{10'd5, 12'd0, 8'h80, 1'b1}},
        // last column of a 7-wide row, counters move to row 1
        '{STEP_PIX, '0,               '0,       8'h7F, 1'b0, 1'b1, '{10'd6, 12'd0, 8'h7F, 1'b1}},
        // height 0 clamps up to 7
        '{STEP_CFG, REG_FRAME_HEIGHT, 12'h000,  8'h00, 1'b0, 1'b0, '0},
        '{STEP_CFG, REG_SPARE_2,      12'hFFF,  8'h00, 1'b0, 1'b0, '0},
        '{STEP_CFG, REG_SPARE_3,      12'h555,  8'h00, 1'b0, 1'b0, '0},
        '{STEP_PIX, '0,               '0,       8'hC3, 1'b1, 1'b1, '{10'd0, 12'd0, 8'hC3, 1'b1}},
        // 2047 clamps down to 1024
        '{STEP_CFG, REG_FRAME_WIDTH,  12'h7FF,  8'h00, 1'b0, 1'b0, '0},
        '{STEP_PIX, '0,               '0,       8'h3C, 1'b0, 1'b1, '{10'd1, 12'd0, 8'h3C, 1'b1}},
        '{STEP_PIX, '0,               '0,       8'h81, 1'b0, 1'b0, '0},
        '{STEP_PIX, '0,               '0,       8'h18, 1'b0, 1'b0, '0},
        '{STEP_PIX, '0,               '0,       8'hE7, 1'b0, 1'b0, '0},
        '{STEP_PIX, '0,               '0,       8'h24, 1'b0, 1'b0, '0},
        '{STEP_PIX, '0,               '0,       8'hDB, 1'b0, 1'b0, '0},
        '{STEP_PIX, '0,               '0,       8'h42, 1'b0, 1'b0, '0},
        '{STEP_PIX, '0,               '0,       8'hBD, 1'b0, 1'b0, '0},
        '{STEP_PIX, '0,               '0,       8'h66, 1'b0, 1'b0, '0},
        // column counter (10) now past the new width: next pixel opens row 1
        '{STEP_CFG, REG_FRAME_WIDTH,  12'd7,    8'h00, 1'b0, 1'b0, '0},
        '{STEP_PIX, '0,               '0,       8'h99, 1'b0, 1'b1, '{10'd0, 12'd1, 8'h99, 1'b1}},
        '{STEP_CFG, REG_FRAME_HEIGHT, 12'hFFF,  8'h00, 1'b0, 1'b0, '0},
        '{STEP_CFG, REG_FRAME_WIDTH,  12'd1024, 8'h00, 1'b0, 1'b0, '0},
        '{STEP_PIX, '0,               '0,       8'hF0, 1'b1, 1'b1, '{10'd0, 12'd0, 8'hF0, 1'b1}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    bmf_cfg_if cfg_if ();
    bmf_pix_if pix_if ();
    bmf_res_if res_if ();

    box_mean_filter_7x7_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_pix   (pix_if),
        .o_res   (res_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor state: registers, raster position, line history, window
    // ---------------------------------------------------------------
    logic [CFG_W_W-1:0]            frame_w;
    logic [CFG_H_W-1:0]            frame_h;
    int                            col_cnt;
    int                            row_cnt;
    logic [LINES-1:0][PIX_W-1:0]   line_mem [MAX_W];  // [k] = LINES-k rows up, oldest at 0
    logic [SPAN-1:0][PIX_W-1:0]    win [SPAN];        // win[SPAN-1] is the newest column

    t_result expected_pixels [$];

    int  error_count;
    int  quiet_cycles;
    bit  src_calm;
    bit  sink_calm;
    bit  hold_req;
    int  stall_left;

    function automatic int eff_width();
        int w;
        w = frame_w;
        if (w < SPAN) w = SPAN;
        if (w > MAX_W) w = MAX_W;
        return w;
    endfunction

    // Append one result to the tail of the expectation queue
    function automatic void queue_expected(input t_result res);
        expected_pixels.insert(expected_pixels.size(), res);
    endfunction

    // Advance the filter by one pixel; queue its results unless the caller
    // supplies them from the directed table.
    function automatic void predict_box_mean(input logic [PIX_W-1:0] pix, input logic fs,
                                             input bit keep);
        int                       w;
        int                       h;
        int                       col;
        int                       row;
        int                       sum;
        int                       n;
        logic [SPAN-1:0][PIX_W-1:0] column;
        t_result                  outs [2];

        w = eff_width();
        h = frame_h;
        if (h < SPAN) h = SPAN;

        if (fs) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        // register change may leave the counters outside the frame
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
        end
        if (row_cnt >= h) row_cnt = 0;
        col = col_cnt;
        row = row_cnt;

        // column history: oldest row at index 0, this pixel on top
        column[LINES-1:0] = line_mem[col];
        column[LINES]     = pix;
        line_mem[col]     = column[LINES:1];
        for (int x = 0; x < SPAN - 1; x++) win[x] = win[x + 1];
        win[SPAN-1] = column;

        n = 0;
        if (row < RAD || row >= h - RAD || col < RAD || col >= w - RAD) begin
            outs[n] = '{COL_OUT_W'(col), ROW_W'(row), pix, 1'b0};
            n++;
        end
        // window centered RAD up and RAD left is now complete
        if (col >= LINES && row >= LINES) begin
            sum = 0;
            for (int x = 0; x < SPAN; x++)
                for (int k = 0; k < SPAN; k++)
                    sum += win[x][k];
            outs[n] = '{COL_OUT_W'(col - RAD), ROW_W'(row - RAD), PIX_W'(sum / AREA), 1'b0};
            n++;
        end
        if (n > 0) outs[n-1].last = 1'b1;
        if (keep)
            for (int i = 0; i < n; i++) queue_expected(outs[i]);

        col_cnt = col + 1;
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt = row + 1;
            if (row_cnt >= h) row_cnt = 0;
        end
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(input t_fill fill);
        case (fill)
            FILL_WHITE: return 8'hFF;
            FILL_BLACK: return 8'h00;
            FILL_SPECKLE: return {PIX_W{$urandom_range(0, 1) == 1}};
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // All tasks below start and end just after a falling edge.
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs, input logic typed,
                              input t_result want);
        int gap;
        gap = pick_gap(src_calm);
        if (gap > 0) begin
            pix_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_if.valid       = 1'b1;
        pix_if.pixel       = pix;
        pix_if.frame_start = fs;
        do @(posedge i_clk); while (!pix_if.ready);
        predict_box_mean(pix, fs, !typed);
        if (typed) queue_expected(want);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid = 1'b1;
        cfg_if.index = index;
        cfg_if.data  = data;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (index == REG_FRAME_WIDTH) frame_w = data[CFG_W_W-1:0];
        else if (index == REG_FRAME_HEIGHT) frame_h = data;
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    // Block is idle once every result is in and the pipe has had time to empty
    task automatic settle();
        pix_if.valid = 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // One stretch of frame data under a new geometry
    task automatic run_phase(input int n_items, input logic [CFG_DATA_W-1:0] w_data,
                             input logic [CFG_DATA_W-1:0] h_data, input t_fill fill,
                             input int hold_at);
        int   old_w;
        bit   fs_first;
        logic fs;
        settle();
        old_w = eff_width();
        if ($urandom_range(0, 1) == 1) begin
            write_reg(REG_FRAME_WIDTH, w_data);
            write_reg(REG_FRAME_HEIGHT, h_data);
        end else begin
            write_reg(REG_FRAME_HEIGHT, h_data);
            write_reg(REG_FRAME_WIDTH, w_data);
        end
        // Widening mid-frame would pull never-written line history into a
        // window, so a wider frame always restarts. Otherwise carry on half
        // the time, which lands on the past-width / past-height wraps.
        fs_first  = (eff_width() > old_w) || ($urandom_range(0, 1) == 1);
        src_calm  = ($urandom_range(0, 3) == 0);
        sink_calm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n_items; i++) begin
            if (i == hold_at) hold_req = 1'b1;
            // occasional restart in mid-frame
            fs = (i == 0 && fs_first) || ($urandom_range(0, 79) == 0);
            send_pixel(pick_pixel(fill), fs, 1'b0, '0);
        end
    endtask

    // ---------------------------------------------------------------
    // Result side: ready with random stalls, one long hold-off on request
    // ---------------------------------------------------------------
    initial begin
        res_if.ready = 1'b0;
        stall_left   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                res_if.ready = 1'b0;
                stall_left--;
            end else begin
                res_if.ready = 1'b1;
                stall_left   = pick_gap(sink_calm);
            end
        end
    end

    // Every result transfer is matched against the oldest expectation
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = '{res_if.out_col, res_if.out_row, res_if.value, res_if.last};
            if (expected_pixels.size() == 0) begin
                if (error_count < MAX_REPORTS)
                    $display("%0t: unexpected result col %0d row %0d value %0d last %0d",
                             $time, got.out_col, got.out_row, got.value, got.last);
                error_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (got !== want) begin
                    if (error_count < MAX_REPORTS)
                        $display({"%0t: mismatch expected col %0d row %0d value %0d last %0d,",
                                  " got col %0d row %0d value %0d last %0d"},
                                 $time, want.out_col, want.out_row, want.value, want.last,
                                 got.out_col, got.out_row, got.value, got.last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: a long run of cycles without any transfer means a hang
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)
            || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_box_mean_filter_7x7_top: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus: directed table, random phases, a short run at maximum width
    // ---------------------------------------------------------------
    initial begin
        int    random_sent;
        int    n_items;
        int    w_pick;
        int    h_pick;
        t_fill fill;

        i_rst_n            = 1'b0;
        pix_if.valid       = 1'b0;
        pix_if.pixel       = '0;
        pix_if.frame_start = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = REG_FRAME_WIDTH;
        cfg_if.data        = '0;
        error_count        = 0;
        quiet_cycles       = 0;
        src_calm           = 1'b0;
        sink_calm          = 1'b0;
        hold_req           = 1'b0;
        frame_w            = 11'd640;
        frame_h            = 12'd480;
        col_cnt            = 0;
        row_cnt            = 0;
        for (int c = 0; c < MAX_W; c++) line_mem[c] = '0;
        for (int x = 0; x < SPAN; x++) win[x] = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_steps[i]) begin
            if (directed_steps[i].kind == STEP_CFG) begin
                settle();
                write_reg(directed_steps[i].index, directed_steps[i].data);
            end else begin
                send_pixel(directed_steps[i].pixel, directed_steps[i].frame_start,
                           directed_steps[i].typed, directed_steps[i].want);
            end
        end

        // Random phases: mostly small frames so windows and frame wraps come
        // quickly; now and then clamped or very tall geometries.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: w_pick = $urandom_range(0, 6);
                1: w_pick = SPAN;
                default: w_pick = $urandom_range(8, 24);
            endcase
            case ($urandom_range(0, 9))
                0: h_pick = $urandom_range(0, 6);
                1: h_pick = SPAN;
                2: h_pick = 4095;
                3: h_pick = $urandom_range(25, 4094);
                default: h_pick = $urandom_range(8, 24);
            endcase
            case ($urandom_range(0, 7))
                0: fill = FILL_WHITE;
                1: fill = FILL_BLACK;
                2: fill = FILL_SPECKLE;
                default: fill = FILL_NOISE;
            endcase
            // first phase is long and carries the output hold-off, so the
            // result queue fills and pixel input backs up
            n_items = (random_sent == 0) ? 200 : $urandom_range(30, 160);
            run_phase(n_items, {$urandom_range(0, 1) == 1, CFG_W_W'(w_pick)},
                      CFG_H_W'(h_pick), fill, (random_sent == 0) ? 20 : -1);
            random_sent += n_items;
        end

        // 1500 clamps to the widest line; a short stretch of row 0 at that width
        run_phase(WIDE_ITEMS, {$urandom_range(0, 1) == 1, 11'd1500}, 12'd7, FILL_NOISE, -1);

        settle();
        if (error_count == 0) begin
            $display("tb_box_mean_filter_7x7_top: clean");
        end else begin
            $display("tb_box_mean_filter_7x7_top: errors");
        end
        $finish;
    end

endmodule
